// File: hw/rtl/escape_rle_pixel_decoder_core_assert.svh
// Assertion macros for the run-length decoder.
`ifndef ESCAPE_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define ESCAPE_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ERPD_ASSERT_IMP(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ERPD_ASSERT_NXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/erpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erpd_pkg;

  localparam int CopiesPerResult = 4;
  localparam int CopiesW         = 3;
  localparam int TotalW          = 9;   // count byte + 1 reaches 256

  typedef enum logic [1:0] {
    MODE_ESC2  = 2'd0,
    MODE_ESC4  = 2'd1,
    MODE_REMAP = 2'd2,
    MODE_RAW   = 2'd3
  } mode_t;

  localparam logic [7:0] EscZero = 8'h00;
  localparam logic [7:0] EscOnes = 8'hFF;
  localparam logic [7:0] Esc55   = 8'h55;
  localparam logic [7:0] EscAa   = 8'hAA;

  function automatic logic [3:0] remap_nibble(input logic [3:0] n);
    logic [3:0] r;
    r = n;
    if (n == 4'h4) r = 4'h5;
    else if (n == 4'h5) r = 4'h6;
    return r;
  endfunction

  function automatic logic [7:0] remap_byte(input logic [7:0] b);
    return {remap_nibble(b[7:4]), remap_nibble(b[3:0])};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/escape_rle_pixel_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Escape / pair run-length decoder for a panel image byte stream.
// Input channel s_*: one stream byte per beat, s_tlast marks the end of a transfer
// chunk, s_tuser carries the compressed and frame start flags.
// Output channel m_*: one decoded pixel byte plus a copy count (1..4) per beat;
// m_tlast marks the last beat released by one input byte.
// Config channel cfg_*: writes the 2-bit decode mode; always ready, write only
// while the stream is idle.
// Latency: the first result of a byte appears on the cycle after its input beat.
// Output: a byte that releases k copies yields ceil(k/4) beats (at least one),
// set by the remaining-count register and its single subtract/compare unit that
// peels off up to four copies per beat. Held or dropped bytes yield no beat.
// A run of 256 copies yields 64 beats; s_tready is low until the last is loaded.
// Reset clears the mode to 0, drops any held run byte and empties the output
// register. When the receiver stalls (m_tready low) the output beat holds and
// s_tready stays low until the output register can take the next beat.
module escape_rle_pixel_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // chunk_last
  input  wire logic [1:0]  s_tuser,   // [0] compressed, [1] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] copies, rest zero
  output logic             m_tlast,   // run_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data   // decode_mode
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  localparam logic [erpd_pkg::TotalW-1:0] Cpr = erpd_pkg::TotalW'(erpd_pkg::CopiesPerResult);

  state_t                          state;
  erpd_pkg::mode_t                 mode;
  logic                            held_valid;
  logic [7:0]                      held_byte;
  logic [erpd_pkg::TotalW-1:0]     rem;
  logic [7:0]                      run_byte;
  logic [7:0]                      out_byte;
  logic [erpd_pkg::CopiesW-1:0]    copies;

  logic                            accept;
  logic                            out_free;
  logic                            pair;
  logic                            held_eff;
  logic                            is_esc;
  logic [7:0]                      dec_value;
  logic [erpd_pkg::TotalW-1:0]     dec_total;
  logic                            held_valid_next;
  logic                            hold_load;
  logic [erpd_pkg::TotalW-1:0]     unit_src;
  logic [erpd_pkg::CopiesW-1:0]    unit_n;
  logic [erpd_pkg::TotalW-1:0]     unit_left;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign pair     = (mode == erpd_pkg::MODE_REMAP) || (mode == erpd_pkg::MODE_RAW);
  assign held_eff = held_valid && !s_tuser[1];
  assign is_esc   = (s_tdata == erpd_pkg::EscZero) || (s_tdata == erpd_pkg::EscOnes) ||
                    ((mode == erpd_pkg::MODE_ESC4) &&
                     ((s_tdata == erpd_pkg::Esc55) || (s_tdata == erpd_pkg::EscAa)));

  // Decode of one accepted byte: value, copy total and held-byte update.
  always_comb begin
    dec_value       = s_tdata;
    dec_total       = '0;
    held_valid_next = held_eff;
    hold_load       = 1'b0;
    priority if (!s_tuser[0]) begin
      dec_value = pair ? erpd_pkg::remap_byte(s_tdata) : s_tdata;
      dec_total = erpd_pkg::TotalW'(1);
    end else if (held_eff) begin
      dec_value       = (mode == erpd_pkg::MODE_REMAP) ? erpd_pkg::remap_byte(held_byte)
                                                       : held_byte;
      dec_total       = (mode == erpd_pkg::MODE_RAW) ? {1'b0, s_tdata}
                                                     : {1'b0, s_tdata} + 9'd1;
      held_valid_next = 1'b0;
    end else if (pair) begin
      held_valid_next = !s_tlast;
      hold_load       = !s_tlast;
    end else if (is_esc) begin
      held_valid_next = 1'b1;
      hold_load       = 1'b1;
    end else begin
      dec_total = erpd_pkg::TotalW'(1);
    end
  end

  // Shared chunk unit: peels up to four copies off the pending total.
  always_comb begin
    unit_src  = (state == ST_IDLE) ? dec_total : rem;
    unit_n    = (unit_src > Cpr) ? erpd_pkg::CopiesW'(erpd_pkg::CopiesPerResult)
                                 : unit_src[erpd_pkg::CopiesW-1:0];
    unit_left = unit_src - erpd_pkg::TotalW'(unit_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= erpd_pkg::MODE_ESC2;
      held_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= erpd_pkg::mode_t'(cfg_data);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            held_valid <= held_valid_next;
            if (hold_load) begin
              held_byte <= s_tdata;
            end else if (s_tuser[1]) begin
              held_byte <= 8'h00;
            end
          end
          if (accept && (dec_total != '0)) begin
            m_tvalid <= 1'b1;
            out_byte <= dec_value;
            run_byte <= dec_value;
            copies   <= unit_n;
            m_tlast  <= (unit_left == '0);
            rem      <= unit_left;
            if (unit_left != '0) begin
              state <= ST_EMIT;
            end
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        // output register always holds a beat here
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_byte <= run_byte;
            copies   <= unit_n;
            m_tlast  <= (unit_left == '0);
            rem      <= unit_left;
            if (unit_left == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, copies, out_byte};

`include "escape_rle_pixel_decoder_core_assert.svh"

  `ERPD_ASSERT_IMP(a_no_accept_in_emit, clk, rst, state == ST_EMIT, !s_tready, "input taken during run")
  `ERPD_ASSERT_IMP(a_emit_has_rem, clk, rst, state == ST_EMIT, rem != '0, "emit state with no copies left")
  `ERPD_ASSERT_IMP(a_copies_range, clk, rst, m_tvalid, (copies != '0) && (copies <= 3'd4), "copy count out of range")
  `ERPD_ASSERT_IMP(a_midrun_in_emit, clk, rst, m_tvalid && !m_tlast, state == ST_EMIT, "run beat without emit state")
  `ERPD_ASSERT_NXT(a_last_beat_idle, clk, rst, (state == ST_EMIT) && out_free && (rem <= Cpr), state == ST_IDLE, "run did not finish")

endmodule

`default_nettype wire

// File: test/tb_escape_rle_pixel_decoder_core.sv
`timescale 1ns / 1ps

module tb_escape_rle_pixel_decoder_core;

  localparam int CycleLimit = 1000000;

  typedef struct {
    logic [7:0] pix;
    logic [2:0] copies;
    logic       run_end;
  } pix_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        s_tlast = 1'b0;    // chunk_last
  logic [1:0]  s_tuser = 2'b00;   // [0] compressed, [1] frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [7:0] out_byte, [10:8] copies, rest zero
  logic        m_tlast;           // run_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'b00;  // decode_mode

  pix_beat_t       beats_due[$];
  erpd_pkg::mode_t mode_now = erpd_pkg::MODE_ESC2;
  logic            held_now = 1'b0;
  logic [7:0]      held_val = 8'h00;
  int              errors = 0;
  int              cycles = 0;
  bit              gaps_on = 1'b1;
  int              sink_hold_req = 0;

  escape_rle_pixel_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("escape_rle_pixel_decoder_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [3:0] shift_level(input logic [3:0] n);
    case (n)
      4'h4:    return 4'h5;
      4'h5:    return 4'h6;
      default: return n;
    endcase
  endfunction

  function automatic logic [7:0] shift_levels(input logic [7:0] b);
    return {shift_level(b[7:4]), shift_level(b[3:0])};
  endfunction

  function automatic bit is_run_byte(input logic [7:0] b);
    return b == erpd_pkg::EscZero || b == erpd_pkg::EscOnes ||
           (mode_now == erpd_pkg::MODE_ESC4 &&
            (b == erpd_pkg::Esc55 || b == erpd_pkg::EscAa));
  endfunction

  function automatic void queue_copies(input logic [7:0] v, input int total);
    int n;
    while (total > 0) begin
      n = (total > erpd_pkg::CopiesPerResult) ? erpd_pkg::CopiesPerResult : total;
      total -= n;
      beats_due.push_back('{v, 3'(n), total == 0});
    end
  endfunction

  function automatic void predict_pixels(input logic [7:0] b, input logic comp,
                                         input logic last, input logic start);
    logic       pair_mode;
    logic [7:0] v;
    pair_mode = (mode_now == erpd_pkg::MODE_REMAP) || (mode_now == erpd_pkg::MODE_RAW);
    if (start) begin
      held_now = 1'b0;
      held_val = 8'h00;
    end
    if (!comp) begin
      queue_copies(pair_mode ? shift_levels(b) : b, 1);
    end else if (held_now) begin
      // held byte finishes under whatever mode is current now
      v = (mode_now == erpd_pkg::MODE_REMAP) ? shift_levels(held_val) : held_val;
      held_now = 1'b0;
      held_val = 8'h00;
      queue_copies(v, (mode_now == erpd_pkg::MODE_RAW) ? int'(b) : int'(b) + 1);
    end else if (pair_mode) begin
      if (!last) begin
        held_now = 1'b1;
        held_val = b;
      end
    end else if (is_run_byte(b)) begin
      held_now = 1'b1;
      held_val = b;
    end else begin
      queue_copies(b, 1);
    end
  endfunction

  // ---------------------------------------------------------------- result side

  initial begin : sink_side
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_beats
    pix_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat: byte %h x%0d last %b", $time, m_tdata[7:0],
                 m_tdata[10:8], m_tlast);
        errors++;
      end else begin
        want = beats_due.pop_front();
        if (m_tdata[7:0] !== want.pix || m_tdata[10:8] !== want.copies ||
            m_tlast !== want.run_end || m_tdata[15:11] !== 5'd0) begin
          $display("%0t: beat mismatch: expected %h x%0d last %b, got %h x%0d last %b pad %h",
                   $time, want.pix, want.copies, want.run_end, m_tdata[7:0], m_tdata[10:8],
                   m_tlast, m_tdata[15:11]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus side

  task automatic send_byte(input logic [7:0] b, input logic comp, input logic last,
                           input logic start);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= {start, comp};
    do @(posedge clk); while (!s_tready);
    predict_pixels(b, comp, last, start);
  endtask

  task automatic wait_pixels_out();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    // a held or dropped byte may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic set_decode_mode(input erpd_pkg::mode_t m);
    wait_pixels_out();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  function automatic logic [7:0] run_count();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
  endfunction

  // One image: run tokens and, outside the pair modes, literals, cut into chunks at random points.
  task automatic send_frame(input int n_tokens);
    logic [7:0] frame_bytes[$];
    bit         cut_ok[$];
    logic [7:0] v;
    bit         pair_mode;
    logic       last_flag;
    pair_mode = (mode_now == erpd_pkg::MODE_REMAP) || (mode_now == erpd_pkg::MODE_RAW);
    for (int i = 0; i < n_tokens; i++) begin
      if (pair_mode || $urandom_range(0, 2) == 0) begin
        if (pair_mode) begin
          v = 8'($urandom);
          if ($urandom_range(0, 2) == 0) v[7:4] = 4'h4 + 4'($urandom_range(0, 1));
          if ($urandom_range(0, 2) == 0) v[3:0] = 4'h4 + 4'($urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, (mode_now == erpd_pkg::MODE_ESC4) ? 3 : 1))
            0:       v = erpd_pkg::EscZero;
            1:       v = erpd_pkg::EscOnes;
            2:       v = erpd_pkg::Esc55;
            default: v = erpd_pkg::EscAa;
          endcase
        end
        // escape runs may straddle a chunk end, pairs only rarely do
        frame_bytes.push_back(v);
        cut_ok.push_back(!pair_mode);
        frame_bytes.push_back(run_count());
        cut_ok.push_back(1'b1);
      end else begin
        do v = 8'($urandom); while (is_run_byte(v));
        frame_bytes.push_back(v);
        cut_ok.push_back(1'b1);
      end
    end
    foreach (frame_bytes[i]) begin
      if ($urandom_range(0, 11) == 0)
        send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      last_flag = (i == frame_bytes.size() - 1) || (cut_ok[i] && $urandom_range(0, 3) == 0);
      if (!cut_ok[i] && $urandom_range(0, 19) == 0) last_flag = 1'b1;
      send_byte(frame_bytes[i], 1'b1, last_flag, i == 0);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_escape_runs();
    set_decode_mode(erpd_pkg::MODE_ESC2);
    send_byte(8'h12, 1'b1, 1'b0, 1'b1);
    send_byte(erpd_pkg::EscZero, 1'b1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0, 1'b0);
    send_byte(erpd_pkg::EscOnes, 1'b1, 1'b0, 1'b0);   // longest run
    send_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0, 1'b0);               // plain literal in this mode
    send_byte(erpd_pkg::EscZero, 1'b1, 1'b1, 1'b0);   // run byte closes the chunk
    send_byte(8'h06, 1'b1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1, 1'b0);
    set_decode_mode(erpd_pkg::MODE_ESC4);
    send_byte(erpd_pkg::Esc55, 1'b1, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0, 1'b0);     // raw beat passes, run byte stays held
    send_byte(8'h03, 1'b1, 1'b0, 1'b0);
    send_byte(erpd_pkg::EscAa, 1'b1, 1'b0, 1'b0);
    send_byte(8'h04, 1'b1, 1'b1, 1'b0);
    send_byte(erpd_pkg::EscOnes, 1'b1, 1'b0, 1'b0);
    send_byte(8'h20, 1'b1, 1'b0, 1'b1);     // new frame drops the held byte
  endtask

  task automatic test_pair_runs();
    set_decode_mode(erpd_pkg::MODE_REMAP);
    send_byte(8'h45, 1'b1, 1'b0, 1'b1);
    send_byte(8'h05, 1'b1, 1'b0, 1'b0);
    send_byte(8'h54, 1'b1, 1'b1, 1'b0);     // unpaired at chunk end, dropped
    send_byte(8'h4F, 1'b0, 1'b0, 1'b0);
    set_decode_mode(erpd_pkg::MODE_RAW);
    send_byte(8'h45, 1'b1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0, 1'b0);     // zero count, no output
    send_byte(8'h00, 1'b1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b0);
    send_byte(8'h54, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_mode_switch_held();
    set_decode_mode(erpd_pkg::MODE_ESC4);
    send_byte(erpd_pkg::Esc55, 1'b1, 1'b1, 1'b1);
    set_decode_mode(erpd_pkg::MODE_REMAP);
    send_byte(8'h02, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_random_stream();
    erpd_pkg::mode_t m;
    for (int k = 0; k < 15; k++) begin
      m = (k < 4) ? erpd_pkg::mode_t'(k) : erpd_pkg::mode_t'($urandom_range(0, 3));
      set_decode_mode(m);
      send_frame($urandom_range(3, 9));
      if (k % 5 == 4) begin
        for (int i = 0; i < 4; i++)
          send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic test_receiver_holdoff();
    set_decode_mode(erpd_pkg::MODE_ESC2);
    sink_hold_req = 200;
    for (int i = 0; i < 8; i++) begin
      send_byte(erpd_pkg::EscOnes, 1'b1, 1'b0, i == 0);
      send_byte(8'd23, 1'b1, 1'b0, 1'b0);
    end
    wait_pixels_out();
    send_frame(4);
  endtask

  task automatic test_steady_tail();
    gaps_on = 1'b0;
    set_decode_mode(erpd_pkg::MODE_REMAP);
    send_frame(8);
    set_decode_mode(erpd_pkg::MODE_ESC4);
    send_frame(8);
    set_decode_mode(erpd_pkg::MODE_RAW);
    send_frame(6);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_escape_runs();
    test_pair_runs();
    test_mode_switch_held();
    test_random_stream();
    test_receiver_holdoff();
    test_steady_tail();
    wait_pixels_out();
    repeat (16) @(posedge clk);
    if (errors == 0 && beats_due.size() == 0)
      $display("escape_rle_pixel_decoder_core regression: pass");
    else
      $display("escape_rle_pixel_decoder_core regression: fail");
    $finish;
  end

endmodule
